FILE: sv/tpdf_pkg.sv
// tpdf_pkg: constants and shared types for the tcp port drop filter
// no dependencies; used by tpdf_parse, tpdf_verdict and the top level
package tpdf_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_W = POS_W + 1;
  localparam int unsigned OFF_W = 7;

  localparam logic [POS_W-1:0] POS_MAX         = '1;
  localparam logic [POS_W-1:0] POS_ETYPE_HI    = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO    = 16'd13;
  localparam logic [POS_W-1:0] POS_IHL         = 16'd14;
  localparam logic [POS_W-1:0] POS_PROTO       = 16'd23;
  localparam logic [OFF_W-1:0] ETH_HDR_LEN     = 7'd14;
  localparam logic [OFF_W-1:0] TCP_HDR_LEN     = 7'd20;
  localparam logic [LEN_W-1:0] MIN_ETH_LEN     = 17'd14;
  localparam logic [LEN_W-1:0] MIN_IP_LEN      = 17'd34;
  localparam logic [15:0]      ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]       PROTO_TCP       = 8'd6;
  localparam logic [15:0]      MATCH_PORT_RESET = 16'd4420;

  // frame fields as they stand once the current byte is taken in
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [15:0]      ether_type;
    logic [7:0]       proto;
    logic [OFF_W-1:0] tcp_end;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
  } frame_view_t;

endpackage

FILE: sv/tpdf_parse.sv
// tpdf_parse: byte position tracking and header field capture
// depends on tpdf_pkg; feeds frame_view_t to tpdf_verdict
module tpdf_parse
  import tpdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output frame_view_t view
);

  logic [POS_W-1:0] pos;
  logic [15:0]      ether_type;
  logic [3:0]       ihl;
  logic [7:0]       proto;
  logic [15:0]      src_port;
  logic [15:0]      dst_port;

  logic [15:0]      ether_type_next;
  logic [3:0]       ihl_next;
  logic [7:0]       proto_next;
  logic [15:0]      src_port_next;
  logic [15:0]      dst_port_next;
  logic [OFF_W-1:0] tcp_off;
  logic [POS_W-1:0] tcp_off_ext;
  logic             past_eth;

  // field capture for the incoming word
  always_comb begin
    ether_type_next = ether_type;
    ihl_next        = ihl;
    proto_next      = proto;
    src_port_next   = src_port;
    dst_port_next   = dst_port;

    if (pos == POS_ETYPE_HI) begin
      ether_type_next[15:8] = data_byte;
    end else if (pos == POS_ETYPE_LO) begin
      ether_type_next[7:0] = data_byte;
    end
    if (pos == POS_IHL) begin
      ihl_next = data_byte[3:0];
    end
    if (pos == POS_PROTO) begin
      proto_next = data_byte;
    end

    // tcp ports sit at 14 + 4*ihl, ihl taken after this word
    tcp_off     = ETH_HDR_LEN + {1'b0, ihl_next, 2'b00};
    tcp_off_ext = {{(POS_W-OFF_W){1'b0}}, tcp_off};
    past_eth    = (pos >= {{(POS_W-OFF_W){1'b0}}, ETH_HDR_LEN});

    if (past_eth) begin
      if (pos == tcp_off_ext) begin
        src_port_next[15:8] = data_byte;
      end else if (pos == tcp_off_ext + 16'd1) begin
        src_port_next[7:0] = data_byte;
      end else if (pos == tcp_off_ext + 16'd2) begin
        dst_port_next[15:8] = data_byte;
      end else if (pos == tcp_off_ext + 16'd3) begin
        dst_port_next[7:0] = data_byte;
      end
    end
  end

  // view of the frame including the current word
  always_comb begin
    view.len        = {1'b0, pos} + 17'd1;
    view.ether_type = ether_type_next;
    view.proto      = proto_next;
    view.tcp_end    = tcp_off + TCP_HDR_LEN;
    view.src_port   = src_port_next;
    view.dst_port   = dst_port_next;
  end

  // frame state, cleared after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_type <= '0;
      ihl        <= '0;
      proto      <= '0;
      src_port   <= '0;
      dst_port   <= '0;
    end else if (take) begin
      if (last_byte) begin
        pos        <= '0;
        ether_type <= '0;
        ihl        <= '0;
        proto      <= '0;
        src_port   <= '0;
        dst_port   <= '0;
      end else begin
        if (pos != POS_MAX) begin
          pos <= pos + 16'd1;
        end
        ether_type <= ether_type_next;
        ihl        <= ihl_next;
        proto      <= proto_next;
        src_port   <= src_port_next;
        dst_port   <= dst_port_next;
      end
    end
  end

endmodule

FILE: sv/tpdf_verdict.sv
// tpdf_verdict: ordered pass/drop rules on the captured frame fields
// depends on tpdf_pkg; driven by tpdf_parse
module tpdf_verdict
  import tpdf_pkg::*;
(
  input  frame_view_t view,
  input  logic [15:0] match_port,
  output logic        drop
);

  // rules in priority order, first hit decides
  always_comb begin
    if (view.len < MIN_ETH_LEN) begin
      drop = 1'b0;
    end else if (view.ether_type != ETHERTYPE_IPV4) begin
      drop = 1'b0;
    end else if (view.len < MIN_IP_LEN) begin
      drop = 1'b1;
    end else if (view.proto != PROTO_TCP) begin
      drop = 1'b0;
    end else if (view.len < {{(LEN_W-OFF_W){1'b0}}, view.tcp_end}) begin
      drop = 1'b1;
    end else if (view.dst_port == match_port || view.src_port == match_port) begin
      drop = 1'b1;
    end else begin
      drop = 1'b0;
    end
  end

endmodule

FILE: sv/tcp_port_drop_filter_top.sv
// tcp_port_drop_filter_top: per-frame ipv4/tcp port filter, top level
// depends on tpdf_pkg, tpdf_parse and tpdf_verdict
//
// Usage:
//   s_* carries an ethernet frame one byte per word, starting at the
//   destination address; s_tlast marks the final byte of the frame.
//   m_* carries one verdict word per frame, bit 0 = drop (1) or pass (0).
//   match_port_we/match_port_wdata load the tcp port to block (either
//   direction); write it only while no frame is in flight.
// Timing:
//   one input word per cycle while s_tready is high. the verdict for a frame
//   appears on m_tvalid in the cycle after its last byte is accepted. every
//   byte updates the frame capture registers and the verdict is formed from
//   them in the same cycle, so there is no per-frame gap.
// Reset:
//   rst (synchronous) clears the frame capture state, empties the output
//   register and sets match_port to 4420.
// Stalls:
//   while m_tvalid is high and m_tready is low, s_tready is low.
module tcp_port_drop_filter_top
  import tpdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] drop, [7:1] zero
  // configuration
  input  logic        match_port_we,
  input  logic [15:0] match_port_wdata
);

  logic [15:0] match_port;
  logic        take;
  logic        drop;
  logic        drop_reg;
  frame_view_t view;

  // output register frees when empty or being taken
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_port <= MATCH_PORT_RESET;
    end else if (match_port_we) begin
      match_port <= match_port_wdata;
    end
  end

  tpdf_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .view      (view)
  );

  tpdf_verdict u_verdict (
    .view       (view),
    .match_port (match_port),
    .drop       (drop)
  );

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      drop_reg <= drop;
    end
  end

  assign m_tdata = {7'd0, drop_reg};

  // a last byte always yields a verdict in the next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("verdict missing after last byte");

  // a taken verdict is not repeated unless a new frame ended
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
    else $error("verdict repeated");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

FILE: tb/tb_tcp_port_drop_filter_top.sv
// tb_tcp_port_drop_filter_top: self-checking bench for the ipv4/tcp port drop filter
// depends on tpdf_pkg and tcp_port_drop_filter_top; frames go in byte by byte,
// each verdict word is checked against a typed value or the per-byte bench parser
`timescale 1ns / 100ps

module tb_tcp_port_drop_filter_top;
  import tpdf_pkg::*;

  localparam int PREDICT     = -1;   // verdict comes from the parser
  localparam int KEEP        = -1;   // leave match_port as it is
  localparam int RAND_BYTES  = 200;
  localparam int RAND_PHASES = 4;

  // one frame of stimulus
  typedef struct packed {
    int          len;
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    int          port_cfg;
    int          drop_typed;
  } frame_spec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        match_port_we = 1'b0;
  logic [15:0] match_port_wdata = 16'h0000;

  // bench-side copy of the frame capture state
  logic [15:0] port_cfg = MATCH_PORT_RESET;
  logic [15:0] frame_pos = '0;
  logic [15:0] etype_seen = '0;
  logic [7:0]  ip_hdr [20];
  logic [15:0] sport_seen = '0;
  logic [15:0] dport_seen = '0;

  logic        drop_verdicts_q [$];
  logic        want_drop;
  int          mismatch_count = 0;
  bit          gaps_on = 1'b1;
  int          rand_bytes_sent = 0;
  frame_spec_t dir_tbl [20];

  tcp_port_drop_filter_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .match_port_we    (match_port_we),
    .match_port_wdata (match_port_wdata)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("%0t: %s: got %02h, expected %02h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // take one accepted byte into the frame state, return the verdict on the last byte
  function automatic logic parse_frame_byte(input logic [7:0] b, input logic last);
    int   toff;
    int   len;
    logic drop;
    if (frame_pos == 16'd12) etype_seen[15:8] = b;
    else if (frame_pos == 16'd13) etype_seen[7:0] = b;
    if (frame_pos >= 16'd14 && frame_pos < 16'd34) ip_hdr[frame_pos - 16'd14] = b;
    toff = 14 + 4 * ip_hdr[0][3:0];
    if (frame_pos >= 16'd14) begin
      if (frame_pos == toff) sport_seen[15:8] = b;
      else if (frame_pos == toff + 1) sport_seen[7:0] = b;
      else if (frame_pos == toff + 2) dport_seen[15:8] = b;
      else if (frame_pos == toff + 3) dport_seen[7:0] = b;
    end
    drop = 1'b0;
    if (last) begin
      len = int'(frame_pos) + 1;
      if (len < 14) drop = 1'b0;
      else if (etype_seen != ETHERTYPE_IPV4) drop = 1'b0;
      else if (len < 34) drop = 1'b1;
      else if (ip_hdr[9] != PROTO_TCP) drop = 1'b0;
      else if (len < toff + 20) drop = 1'b1;
      else if (dport_seen == port_cfg) drop = 1'b1;
      else if (sport_seen == port_cfg) drop = 1'b1;
      // frame done, clear capture
      frame_pos = '0;
      etype_seen = '0;
      sport_seen = '0;
      dport_seen = '0;
      for (int i = 0; i < 20; i++) ip_hdr[i] = '0;
    end else if (frame_pos != 16'hFFFF) begin
      frame_pos++;
    end
    return drop;
  endfunction

  // drive one word and hold it until accepted; while gaps_on is set, a random gap may come before it
  task automatic send_word(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // build a frame around the given header fields, random filler elsewhere
  task automatic send_frame(input frame_spec_t f);
    int         toff;
    logic [7:0] b;
    logic       drop;
    toff = 14 + 4 * f.ver_ihl[3:0];
    for (int i = 0; i < f.len; i++) begin
      b = 8'($urandom);
      if (i == toff) b = f.sport[15:8];
      else if (i == toff + 1) b = f.sport[7:0];
      else if (i == toff + 2) b = f.dport[15:8];
      else if (i == toff + 3) b = f.dport[7:0];
      if (i == 12) b = f.etype[15:8];
      else if (i == 13) b = f.etype[7:0];
      else if (i == 14) b = f.ver_ihl;
      else if (i == 23) b = f.proto;
      send_word(b, i == f.len - 1);
      drop = parse_frame_byte(b, i == f.len - 1);
      if (i == f.len - 1)
        drop_verdicts_q.push_back(f.drop_typed == PREDICT ? drop : f.drop_typed[0]);
    end
  endtask

  // load match_port once every verdict is out and the block has settled
  task automatic write_match_port(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (drop_verdicts_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    match_port_we    <= 1'b1;
    match_port_wdata <= v;
    @(posedge clk);
    match_port_we <= 1'b0;
    port_cfg = v;
  endtask

  // random frame, often well-formed ipv4/tcp with random content
  task automatic send_random_frame();
    frame_spec_t f;
    int          kind;
    int          need;
    kind = $urandom_range(99);
    f.etype      = ETHERTYPE_IPV4;
    f.ver_ihl    = (kind < 10) ? 8'h46 : 8'h45;
    f.proto      = PROTO_TCP;
    f.sport      = 16'($urandom);
    f.dport      = 16'($urandom);
    f.port_cfg   = KEEP;
    f.drop_typed = PREDICT;
    case ($urandom_range(2))
      0: f.sport = port_cfg;
      1: f.dport = port_cfg;
      default: ;
    endcase
    if (kind >= 60 && kind < 75) begin
      f.ver_ihl = 8'($urandom);
    end else if (kind >= 75 && kind < 85) begin
      f.proto = 8'($urandom);
    end else if (kind >= 85 && kind < 92) begin
      f.etype = 16'($urandom);
    end else if (kind >= 92) begin
      f.ver_ihl = 8'($urandom);
      f.proto   = 8'($urandom);
      if ($urandom_range(1)) f.etype = 16'($urandom);
    end
    need = 14 + 4 * f.ver_ihl[3:0] + 20;
    if (need < 34) need = 34;
    if ($urandom_range(99) < 20) f.len = $urandom_range(1, need - 1);
    else f.len = need + $urandom_range(0, 12);
    send_frame(f);
    rand_bytes_sent += f.len;
  endtask

  // verdict checker and output backpressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drop_verdicts_q.size() == 0) begin
        report_mismatch("verdict word with none outstanding", m_tdata, 8'h00);
      end else begin
        want_drop = drop_verdicts_q.pop_front();
        if (m_tdata !== {7'b0, want_drop})
          report_mismatch("drop verdict", m_tdata, {7'b0, want_drop});
      end
    end
    m_tready <= gaps_on ? ($urandom_range(99) >= 37) : 1'b1;
  end

  // main sequence
  initial begin
    int          phase_bytes;
    int          phase_frames;
    logic [15:0] phase_port;
    for (int i = 0; i < 20; i++) ip_hdr[i] = '0;
    // len, etype, ver/ihl, proto, sport, dport, match_port, drop
    dir_tbl = '{
      '{1,     16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd2,     KEEP,  0},
      '{13,    16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd2,     KEEP,  0},
      '{14,    16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd2,     KEEP,  1},
      '{14,    16'h86DD, 8'h45, PROTO_TCP, 16'd4420,  16'd4420,  KEEP,  0},
      '{33,    16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd2,     KEEP,  1},
      '{34,    16'h0800, 8'h45, 8'd17,     16'd4420,  16'd4420,  KEEP,  0},
      '{53,    16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd2,     KEEP,  1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'd1,     16'd4420,  KEEP,  1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'd4420,  16'd80,    KEEP,  1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'd80,    16'd443,   KEEP,  0},
      '{93,    16'h0800, 8'h4F, PROTO_TCP, 16'd80,    16'd443,   KEEP,  1},
      '{94,    16'h0800, 8'hFF, PROTO_TCP, 16'd4420,  16'd443,   KEEP,  PREDICT},
      '{40,    16'h0800, 8'h40, PROTO_TCP, 16'd80,    16'd443,   KEEP,  PREDICT},
      '{44,    16'h0800, 8'h42, PROTO_TCP, 16'd80,    16'd443,   KEEP,  PREDICT},
      '{40,    16'h0800, 8'h44, PROTO_TCP, 16'd4420,  16'd443,   KEEP,  PREDICT},
      '{80,    16'h0800, 8'h45, PROTO_TCP, 16'd80,    16'd4420,  KEEP,  1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'd1234,  16'd0,     0,     1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'd4420,  16'd80,    KEEP,  0},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'hFFFF,  16'd80,    65535, 1},
      '{54,    16'h0800, 8'h45, PROTO_TCP, 16'h0000,  16'h7FFF,  KEEP,  PREDICT}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames
    for (int i = 0; i < $size(dir_tbl); i++) begin
      if (dir_tbl[i].port_cfg != KEEP) write_match_port(dir_tbl[i].port_cfg[15:0]);
      send_frame(dir_tbl[i]);
    end

    // random phases, one match_port setting each, one phase with no idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: phase_port = MATCH_PORT_RESET;
        2: phase_port = 16'h0000;
        3: phase_port = 16'hFFFF;
        default: phase_port = 16'($urandom);
      endcase
      write_match_port(phase_port);
      gaps_on      = (p != 2);
      phase_bytes  = rand_bytes_sent;
      phase_frames = 0;
      while (rand_bytes_sent - phase_bytes < RAND_BYTES / RAND_PHASES || phase_frames == 0) begin
        send_random_frame();
        phase_frames++;
      end
    end

    // drain
    s_tvalid <= 1'b0;
    gaps_on = 1'b1;
    while (drop_verdicts_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tpdf_pkg.sv
sv/tpdf_parse.sv
sv/tpdf_verdict.sv
sv/tcp_port_drop_filter_top.sv
tb/tb_tcp_port_drop_filter_top.sv
